// ===== src/ar2u_pkg.sv =====
// ----------------------------------------------------------------------------
// ar2u_pkg: shared types and constants for the ASCII radix converter
// Holds the string length limit, radix codes, status codes and the
// structures that pass between the converter stages.
// ----------------------------------------------------------------------------
`default_nettype none

package ar2u_pkg;

  // Longest string whose positions are counted; the counter saturates below it.
  localparam int MAX_STRING_LENGTH = 4096;
  localparam int POS_W             = $clog2(MAX_STRING_LENGTH);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_LENGTH - 1);

  // Field widths of the character and the result.
  localparam int CHAR_W   = 8;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 12;
  localparam int BASE_W   = 5;
  localparam int DIGIT_W  = 4;
  localparam int PROD_W   = VALUE_W + 4;
  localparam int OUT_W    = 80;

  // Radix codes.
  localparam logic [BASE_W-1:0] BASE_2     = 5'd2;
  localparam logic [BASE_W-1:0] BASE_8     = 5'd8;
  localparam logic [BASE_W-1:0] BASE_10    = 5'd10;
  localparam logic [BASE_W-1:0] BASE_16    = 5'd16;
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_10;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_DIGITS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_BASE  = 2'd3;

  // ASCII codes used by the digit decoder.
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_F  = 8'h46;
  localparam logic [CHAR_W-1:0] HEX_OFFS = 8'd10;

  // Decoded character held in the input register.
  typedef struct packed {
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } ar2u_char_t;

  // One conversion result.
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  stop_index;
    logic                stopped_early;
  } ar2u_result_t;

endpackage

`default_nettype wire

// ===== src/ar2u_in_stage.sv =====
// ----------------------------------------------------------------------------
// ar2u_in_stage: input register and digit decoder
// Registers each accepted character together with its last flag and its
// digit value in any supported radix (hex letters in either case).
// ----------------------------------------------------------------------------
`default_nettype none

module ar2u_in_stage (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [ar2u_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] char_code
  input  wire logic                            s_tlast,   // last_char
  input  wire logic                            take,
  output logic                                 item_valid,
  output ar2u_pkg::ar2u_char_t                 item
);

  ar2u_pkg::ar2u_char_t decoded;

  // Digit value of the character, flagged when it is a digit in radix 16.
  always_comb begin
    decoded.last     = s_tlast;
    decoded.is_digit = 1'b1;
    decoded.digit    = '0;
    if (s_tdata >= ar2u_pkg::CH_0 && s_tdata <= ar2u_pkg::CH_9) begin
      decoded.digit = ar2u_pkg::DIGIT_W'(s_tdata - ar2u_pkg::CH_0);
    end else if (s_tdata >= ar2u_pkg::CH_LC_A && s_tdata <= ar2u_pkg::CH_LC_F) begin
      decoded.digit = ar2u_pkg::DIGIT_W'(s_tdata - ar2u_pkg::CH_LC_A + ar2u_pkg::HEX_OFFS);
    end else if (s_tdata >= ar2u_pkg::CH_UC_A && s_tdata <= ar2u_pkg::CH_UC_F) begin
      decoded.digit = ar2u_pkg::DIGIT_W'(s_tdata - ar2u_pkg::CH_UC_A + ar2u_pkg::HEX_OFFS);
    end else begin
      decoded.is_digit = 1'b0;
    end
  end

  // The register may load whenever it is empty or its content moves on.
  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= decoded;
    end
  end

endmodule

`default_nettype wire

// ===== src/ar2u_accum.sv =====
// ----------------------------------------------------------------------------
// ar2u_accum: radix register, per-string state and result formation
// Folds one digit per cycle, unless stalled, into the 64-bit accumulator with
// exact overflow detection and forms the result on the last character of a string.
// ----------------------------------------------------------------------------
`default_nettype none

module ar2u_accum (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [ar2u_pkg::BASE_W-1:0]   cfg_data,
  input  wire logic                          item_valid,
  input  wire ar2u_pkg::ar2u_char_t          item,
  input  wire logic                          out_free,
  output logic                               take,
  output logic                               res_valid,
  output ar2u_pkg::ar2u_result_t             res
);

  logic [ar2u_pkg::BASE_W-1:0]  base;
  logic [ar2u_pkg::VALUE_W-1:0] accumulator;
  logic [ar2u_pkg::VALUE_W-1:0] accumulator_next;
  logic [ar2u_pkg::POS_W-1:0]   char_position;
  logic [ar2u_pkg::POS_W-1:0]   char_position_next;
  logic                         digits_halted;
  logic                         digits_halted_next;
  logic                         overflowed;
  logic                         overflowed_next;
  logic [ar2u_pkg::POS_W-1:0]   halt_position;
  logic [ar2u_pkg::POS_W-1:0]   halt_position_next;

  logic                         base_ok;
  logic                         live;
  logic                         digit_ok;
  logic [ar2u_pkg::PROD_W-1:0]  acc_wide;
  logic [ar2u_pkg::PROD_W-1:0]  scaled;
  logic [ar2u_pkg::PROD_W-1:0]  sum;

  // Radix register; the user must write it only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= ar2u_pkg::BASE_RESET;
    end else if (cfg_write) begin
      base <= cfg_data;
    end
  end

  assign base_ok = (base == ar2u_pkg::BASE_2) || (base == ar2u_pkg::BASE_8) ||
                   (base == ar2u_pkg::BASE_10) || (base == ar2u_pkg::BASE_16);
  assign live     = base_ok && !digits_halted && !overflowed;
  assign digit_ok = item.is_digit && ({1'b0, item.digit} < base);

  // The radix is a power of two or ten, so scaling is shifts and one add.
  assign acc_wide = {4'b0000, accumulator};
  always_comb begin
    unique case (base)
      ar2u_pkg::BASE_2:  scaled = acc_wide << 1;
      ar2u_pkg::BASE_8:  scaled = acc_wide << 3;
      ar2u_pkg::BASE_10: scaled = (acc_wide << 3) + (acc_wide << 1);
      default:           scaled = acc_wide << 4;
    endcase
  end
  assign sum = scaled + ar2u_pkg::PROD_W'(item.digit);

  // Next state of the string after this character.
  always_comb begin
    accumulator_next   = accumulator;
    digits_halted_next = digits_halted;
    overflowed_next    = overflowed;
    halt_position_next = halt_position;
    if (live) begin
      if (digit_ok) begin
        if (|sum[ar2u_pkg::PROD_W-1:ar2u_pkg::VALUE_W]) begin
          overflowed_next = 1'b1;
        end else begin
          accumulator_next = sum[ar2u_pkg::VALUE_W-1:0];
        end
      end else begin
        digits_halted_next = 1'b1;
        halt_position_next = char_position;
      end
    end
    if (char_position != ar2u_pkg::POS_MAX) begin
      char_position_next = char_position + 1'b1;
    end else begin
      char_position_next = char_position;
    end
  end

  // A character moves on unless it ends a string and the result slot is full.
  assign take      = item_valid && (!item.last || out_free);
  assign res_valid = take && item.last;

  // Result on the last character, in order of precedence.
  always_comb begin
    res.value         = accumulator_next;
    res.status        = ar2u_pkg::ST_OK;
    res.stop_index    = '0;
    res.stopped_early = 1'b0;
    if (!base_ok) begin
      res.value  = '0;
      res.status = ar2u_pkg::ST_BAD_BASE;
    end else if (overflowed_next) begin
      res.value  = '1;
      res.status = ar2u_pkg::ST_RANGE;
    end else if (digits_halted_next) begin
      res.stop_index    = ar2u_pkg::INDEX_W'(halt_position_next);
      res.stopped_early = 1'b1;
      if (halt_position_next == '0) begin
        res.value  = '0;
        res.status = ar2u_pkg::ST_NO_DIGITS;
      end
    end
  end

  // Per-string state, cleared after each result.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      char_position <= '0;
      digits_halted <= 1'b0;
      overflowed    <= 1'b0;
      halt_position <= '0;
    end else if (take) begin
      if (item.last) begin
        accumulator   <= '0;
        char_position <= '0;
        digits_halted <= 1'b0;
        overflowed    <= 1'b0;
        halt_position <= '0;
      end else begin
        accumulator   <= accumulator_next;
        char_position <= char_position_next;
        digits_halted <= digits_halted_next;
        overflowed    <= overflowed_next;
        halt_position <= halt_position_next;
      end
    end
  end

  // A string either stops at a non-digit or overflows, never both.
  a_halt_excl_ovf: assert property (@(posedge clk) disable iff (rst)
    !(digits_halted && overflowed))
    else $error("stop and overflow flags both set");

  // The string state is clear after a result.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && item.last |=> accumulator == '0 && char_position == '0 && !overflowed)
    else $error("string state not cleared after a result");

  // Overflow is sticky until the string ends.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflowed && !(take && item.last) |=> overflowed)
    else $error("overflow flag dropped inside a string");

  // The position advances by one per character until it saturates.
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    take && !item.last && char_position != ar2u_pkg::POS_MAX
    |=> char_position == $past(char_position) + 1'b1)
    else $error("character position did not advance");

endmodule

`default_nettype wire

// ===== src/ar2u_out_reg.sv =====
// ----------------------------------------------------------------------------
// ar2u_out_reg: result register on the output stream
// Holds one finished result until the receiver takes it, and packs the
// result fields into the output data word.
// ----------------------------------------------------------------------------
`default_nettype none

module ar2u_out_reg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          res_valid,
  input  wire ar2u_pkg::ar2u_result_t        res,
  output logic                               out_free,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [ar2u_pkg::OUT_W-1:0]         m_tdata
);

  ar2u_pkg::ar2u_result_t held;

  // The slot is free when empty or when its result is taken this cycle.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      held <= res;
    end
  end

  // Fields from the lowest bit up, padded with zeros to whole bytes.
  assign m_tdata = {1'b0, held.stopped_early, held.stop_index, held.status, held.value};

endmodule

`default_nettype wire

// ===== src/ascii_radix_to_uint64_unit.sv =====
// ----------------------------------------------------------------------------
// ascii_radix_to_uint64_unit: streamed ASCII number to unsigned 64-bit value
// Converts a string in radix 2, 8, 10 or 16 into a 64-bit value with status.
// ----------------------------------------------------------------------------
// Characters arrive on the slave stream, one per transfer, with tlast on the
// final character of each string. One result leaves on the master stream per
// string, after its last character: value, status, stop position and a flag
// for a string that stopped at a non-digit.
// The radix is written on the cfg channel, which is always ready; write it
// only between strings. After reset the radix is 10 and no string is open.
// The last character of a string lands in the input register at its transfer;
// the result formed from it loads into the result register, which offers it.
// Characters are taken one per cycle, but a last character waits while the
// result register is full; the accumulator loop (shift-and-add scaling, digit
// add and overflow test) is combinational around the accumulator register.
// When the receiver stalls, the held result waits in the result register;
// characters that do not end a string keep flowing, and a last character
// waits in the input register until the result register frees, which then
// back-pressures the slave stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_radix_to_uint64_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ar2u_pkg::BASE_W-1:0]   cfg_data,   // [4:0] number_base
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [ar2u_pkg::CHAR_W-1:0]   s_tdata,    // [7:0] char_code
  input  wire logic                          s_tlast,    // last_char
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [63:0] value, [65:64] status, [77:66] stop_index, [78] stopped_early,
  // [79] zero
  output logic [ar2u_pkg::OUT_W-1:0]         m_tdata
);

  logic                    item_valid;
  ar2u_pkg::ar2u_char_t    item;
  logic                    take;
  logic                    res_valid;
  ar2u_pkg::ar2u_result_t  res;
  logic                    out_free;

  // The radix register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Input register and digit decoder.
  ar2u_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Accumulator, string state and result logic.
  ar2u_accum u_acc (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register on the master stream.
  ar2u_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
